/* design/aes_key_schedule_macros.svh */
// Assertion macros used by the key schedule controller.
`ifndef AES_KEY_SCHEDULE_MACROS_SVH
`define AES_KEY_SCHEDULE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define AKS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that implies a consequence in the same cycle.
`define AKS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that implies a consequence in the next cycle.
`define AKS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/aks_pkg.sv */
// Package with constants, types and functions of the AES key schedule.
package aks_pkg;

    localparam int MAX_KEY_WORDS = 8;
    localparam int WORD_W        = 32;
    localparam int NUM_W         = 6;
    localparam int WIN_IDX_W     = $clog2(MAX_KEY_WORDS);
    localparam int NK_W          = $clog2(MAX_KEY_WORDS) + 1;
    localparam int MODE_W        = 2;
    localparam int ROUND_W       = 4;
    localparam int CFG_DATA_W    = 4;
    localparam int TDATA_OUT_W   = 40;

    localparam logic [ROUND_W-1:0] MAX_ROUNDS   = 4'd14;
    localparam logic [ROUND_W-1:0] ROUNDS_RESET = 4'd10;
    localparam logic [7:0]         RCON_INIT    = 8'h8d;
    localparam logic [8:0]         GF_POLY      = 9'h11b;

    localparam logic [MODE_W-1:0] KEY_128 = 2'd0;
    localparam logic [MODE_W-1:0] KEY_192 = 2'd1;

    localparam logic CFG_KEY_SIZE = 1'b0;
    localparam logic CFG_ROUNDS   = 1'b1;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    typedef struct packed {
        logic                 load_word;
        logic [WIN_IDX_W-1:0] load_idx;
        logic                 expand_init;
        logic                 step;
        logic                 key_phase;
        logic [NUM_W-1:0]     word_idx;
        logic                 rcon_step;
        logic                 sub_only;
        logic                 last;
    } aks_cmd_t;

    typedef struct packed {
        logic             out_free;
        logic [NK_W-1:0]  nk;
        logic [NUM_W-1:0] total;
    } aks_sts_t;

    function automatic logic [7:0] next_rcon(input logic [7:0] r);
        logic [7:0] v;
        begin
            v = {r[6:0], 1'b0};
            if (r[7])
            begin
                v = v ^ GF_POLY[7:0];
            end
            return v;
        end
    endfunction

    function automatic logic [WORD_W-1:0] sub_word(input logic [WORD_W-1:0] w);
        begin
            return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
        end
    endfunction

endpackage

/* design/aks_datapath.sv */
// Datapath of the key schedule: key window, word history, round constant and output register.
module aks_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic                               cfg_index,
    input  logic [aks_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [aks_pkg::WORD_W-1:0]         key_word,
    input  aks_pkg::aks_cmd_t                  cmd,
    output aks_pkg::aks_sts_t                  sts,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [aks_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast
);
    import aks_pkg::*;

    logic [MODE_W-1:0]    mode_reg;
    logic [ROUND_W-1:0]   rounds_reg;
    logic [WORD_W-1:0]    window_reg [MAX_KEY_WORDS];
    logic [WORD_W-1:0]    hist_reg [MAX_KEY_WORDS];
    logic [7:0]           rcon_reg;
    logic [7:0]           rcon_next;
    logic                 out_valid_reg;
    logic [WORD_W-1:0]    out_word_reg;
    logic [NUM_W-1:0]     out_num_reg;
    logic                 out_last_reg;

    logic [NK_W-1:0]      nk;
    logic [ROUND_W-1:0]   rounds_eff;
    logic [ROUND_W-1:0]   rounds_p1;
    logic [WIN_IDX_W-1:0] back_idx;
    logic [WORD_W-1:0]    prev_word;
    logic [WORD_W-1:0]    back_word;
    logic [WORD_W-1:0]    temp_word;
    logic [WORD_W-1:0]    new_word;

    always_comb
    begin
        unique case (mode_reg)
            KEY_128: nk = NK_W'(4);
            KEY_192: nk = NK_W'(6);
            default: nk = NK_W'(MAX_KEY_WORDS);
        endcase
        rounds_eff = (rounds_reg > MAX_ROUNDS) ? MAX_ROUNDS : rounds_reg;
        rounds_p1  = rounds_eff + ROUND_W'(1);
    end

    assign sts.nk       = nk;
    assign sts.total    = {rounds_p1, 2'b00};
    assign sts.out_free = !out_valid_reg || m_axis_tready;

    assign back_idx  = WIN_IDX_W'(nk - NK_W'(1));
    assign prev_word = hist_reg[0];
    assign back_word = hist_reg[back_idx];
    assign rcon_next = next_rcon(rcon_reg);

    always_comb
    begin
        priority if (cmd.rcon_step)
        begin
            temp_word = sub_word({prev_word[23:0], prev_word[31:24]}) ^ {rcon_next, 24'h0};
        end
        else if (cmd.sub_only)
        begin
            temp_word = sub_word(prev_word);
        end
        else
        begin
            temp_word = prev_word;
        end
        new_word = cmd.key_phase ? window_reg[cmd.word_idx[WIN_IDX_W-1:0]]
                                 : (temp_word ^ back_word);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= KEY_128;
            rounds_reg <= ROUNDS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_KEY_SIZE: mode_reg   <= cfg_data[MODE_W-1:0];
                CFG_ROUNDS:   rounds_reg <= cfg_data[ROUND_W-1:0];
                default:      mode_reg   <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_word)
        begin
            window_reg[cmd.load_idx] <= key_word;
        end
        if (cmd.step)
        begin
            hist_reg[0] <= new_word;
            for (int k = 1; k < MAX_KEY_WORDS; k++)
            begin
                hist_reg[k] <= hist_reg[k-1];
            end
            out_word_reg <= new_word;
            out_num_reg  <= cmd.word_idx;
            out_last_reg <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcon_reg      <= RCON_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.expand_init)
            begin
                rcon_reg <= RCON_INIT;
            end
            else if (cmd.step && cmd.rcon_step)
            begin
                rcon_reg <= rcon_next;
            end
            if (cmd.step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(TDATA_OUT_W - WORD_W - NUM_W){1'b0}}, out_num_reg, out_word_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

/* design/aks_ctrl.sv */
// Controller of the key schedule: key loading count, word sequencing and state.
`include "aes_key_schedule_macros.svh"

module aks_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  aks_pkg::aks_sts_t sts,
    output aks_pkg::aks_cmd_t cmd
);
    import aks_pkg::*;

    localparam logic S_LOAD   = 1'b0;
    localparam logic S_EXPAND = 1'b1;

    logic                 state_reg;
    logic                 state_next;
    logic [WIN_IDX_W-1:0] count_reg;
    logic [WIN_IDX_W-1:0] count_next;
    logic [NUM_W-1:0]     word_reg;
    logic [NUM_W-1:0]     word_next;
    logic [WIN_IDX_W-1:0] pos_reg;
    logic [WIN_IDX_W-1:0] pos_next;

    logic                 accept;
    logic [NK_W-1:0]      count_inc;
    logic                 key_done;
    logic                 key_phase;

    assign s_axis_tready = (state_reg == S_LOAD);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign count_inc     = {1'b0, count_reg} + NK_W'(1);
    assign key_done      = (count_inc >= sts.nk);
    assign key_phase     = (word_reg < NUM_W'(sts.nk));

    always_comb
    begin
        cmd.load_word   = accept;
        cmd.load_idx    = count_reg;
        cmd.expand_init = accept && key_done;
        cmd.step        = (state_reg == S_EXPAND) && sts.out_free;
        cmd.key_phase   = key_phase;
        cmd.word_idx    = word_reg;
        cmd.rcon_step   = !key_phase && (pos_reg == '0);
        cmd.sub_only    = !key_phase && (sts.nk > NK_W'(6)) && (pos_reg == WIN_IDX_W'(4));
        cmd.last        = (word_reg == sts.total - NUM_W'(1));
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        word_next  = word_reg;
        pos_next   = pos_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (key_done)
                    begin
                        state_next = S_EXPAND;
                        count_next = '0;
                        word_next  = '0;
                        pos_next   = '0;
                    end
                    else
                    begin
                        count_next = count_inc[WIN_IDX_W-1:0];
                    end
                end
            end
            S_EXPAND:
            begin
                if (cmd.step)
                begin
                    word_next = word_reg + NUM_W'(1);
                    pos_next  = ({1'b0, pos_reg} == sts.nk - NK_W'(1)) ? '0
                                                                      : pos_reg + WIN_IDX_W'(1);
                    if (cmd.last)
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            word_reg  <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            word_reg  <= word_next;
            pos_reg   <= pos_next;
        end
    end

    `AKS_ASSERT_IMP(a_no_load_in_expand, state_reg == S_EXPAND, !cmd.load_word && count_reg == '0, "key word loaded during expansion")
    `AKS_ASSERT_IMP(a_step_needs_room, cmd.step, sts.out_free, "word produced while the output register is full")
    `AKS_ASSERT_NEXT(a_last_ends_expand, cmd.step && cmd.last, state_reg == S_LOAD, "expansion did not end after the last word")
    `AKS_ASSERT_NEXT(a_start_from_zero, cmd.expand_init, word_reg == '0 && pos_reg == '0, "expansion started at a nonzero word")
    `AKS_ASSERT_ALWAYS(a_pos_in_range, {1'b0, pos_reg} < sts.nk || state_reg == S_LOAD, "word position beyond key length")

endmodule

/* design/aes_key_schedule.sv */
// Top level of the AES key expansion for 128-, 192- and 256-bit keys.
//
//  Channel   Direction  Handshake              Payload
//  s_axis    in         tvalid/tready          tdata: key_word[31:0]
//  m_axis    out        tvalid/tready          tdata: round_key_word[31:0], word_number[37:32];
//                                              tlast: last_word
//  cfg       in         cfg_valid/cfg_ready    cfg_index (0 key size, 1 rounds), cfg_data
//
// Key words are taken one per cycle while loading; the Nk-th word starts the expansion.
// The expansion produces one word per cycle while the output is not stalled,
// through a single S-box stage, and a key yields 4*(rounds+1) words in all.
// No key word is taken while the expansion runs; a stalled output pauses it.
// Reset clears the load count, sets the round constant to 0x8d and the
// registers to a 128-bit key with ten rounds.
module aes_key_schedule (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // key_word[31:0]
    input  logic [aks_pkg::WORD_W-1:0]         s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // round_key_word[31:0], word_number[37:32], zero fill[39:38]
    output logic [aks_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_index,
    input  logic [aks_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import aks_pkg::*;

    aks_cmd_t cmd;
    aks_sts_t sts;

    assign cfg_ready = 1'b1;

    aks_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    aks_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .key_word      (s_axis_tdata),
        .cmd           (cmd),
        .sts           (sts),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
